FILE: hdl/wli_pkg.sv
// ----------------------------------------------------------------------------
// wli_pkg: shared constants for the waypoint linear interpolator
// Fixed-point constants, register map and widths used by the interpolator and divider.
// ----------------------------------------------------------------------------
package wli_pkg;

  localparam int unsigned MAX_STEPS_DEF = 64;
  localparam int unsigned CNT_W         = 7;   // holds 0..64
  localparam int unsigned IDX_W         = 6;   // setpoint index 0..63

  localparam int unsigned DVD_W = 49;          // dividend / quotient width
  localparam int unsigned DVS_W = 32;          // divisor width

  localparam logic signed [33:0] PI_Q16     = 34'sd205887;
  localparam logic signed [33:0] TWO_PI_Q16 = 34'sd411775;

  localparam logic [31:0] SPEED_RST = 32'h0000_8000;
  localparam logic [31:0] YAW_RST   = 32'h0000_C000;
  localparam logic [31:0] STEP_RST  = 32'h0001_0000;

  localparam logic [1:0] REG_SPEED = 2'd0;
  localparam logic [1:0] REG_YAW   = 2'd1;
  localparam logic [1:0] REG_STEP  = 2'd2;

endpackage

FILE: hdl/waypoint_linear_interpolator.sv
// ----------------------------------------------------------------------------
// waypoint_linear_interpolator: linear setpoint generator between waypoints
// Sequencer around a shared divider, square root unit and two multipliers.
// ----------------------------------------------------------------------------
// Usage: each in_ beat carries a waypoint (x, y, z, heading) and a restart
// flag. The first waypoint after reset, or any beat with restart set, is only
// stored. Every other waypoint produces 0..MAX_STEPS out_ beats stepping
// linearly from the stored waypoint toward the new one; tuser marks the last.
// in_tready is high only while the block is idle: a waypoint is taken, then
// processed to completion before the next one is accepted.
// Setting up a segment takes three squares, a root and up to three
// divisions (two when the step period is zero); each setpoint then takes
// four offsets, each a pass of the shared divider. All divisions share
// one restoring divider.
// A stalled out_tready holds the current beat and stops the sequencer.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// the stored waypoint. The cfg_ port is an APB slave at byte addresses 0, 4, 8
// (speed limit, yaw rate limit, step period); write only while idle.
// ----------------------------------------------------------------------------
module waypoint_linear_interpolator #(
  parameter int unsigned MAX_STEPS = wli_pkg::MAX_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // pos_x, pos_y, pos_z, heading
  input  logic         in_tuser,  // restart
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata, // set_x, set_y, set_z, set_heading
  output logic         out_tuser, // last_step
  // configuration
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int unsigned CW = wli_pkg::CNT_W;
  localparam int unsigned IW = wli_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_SQ, S_SQACC, S_ROOT, S_DLIN, S_DYAW, S_DCNT,
    S_MUL, S_DOFF, S_OUT
  } state_t;

  state_t state_r;

  logic [31:0] speed_r, yaw_r, step_r;
  logic [31:0] prev_r [4];
  logic [31:0] cur_r  [4];
  logic [31:0] set_r  [4];
  logic signed [32:0] delta_r [4];
  logic        have_prev_r;
  logic [63:0] sum_r, prod_r;
  logic [1:0]  k_r;
  logic [IW-1:0] i_r;
  logic [CW-1:0] count_r;
  logic [wli_pkg::DVD_W-1:0] tlin_r;
  logic        last_r;

  // shared units
  logic                      div_start, div_done, sq_start, sq_done;
  logic [wli_pkg::DVD_W-1:0] div_dvd, div_q;
  logic [wli_pkg::DVS_W-1:0] div_dvs;
  logic [31:0]               sq_root;
  logic [63:0]               sq_in;

  wli_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .quotient(div_q), .done(div_done)
  );

  wli_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_in),
    .root(sq_root), .done(sq_done)
  );

  // ---- helpers ----
  logic [32:0] mag_k, mag_yaw;
  logic [31:0] half_k;
  logic signed [33:0] yw1, yw2;
  logic [wli_pkg::DVD_W-1:0] tseg;
  logic [38:0] mprod;
  logic signed [34:0] off_s, sum_s;
  logic [31:0] clamped;
  logic        in_acc, out_acc, cfg_wr;

  always_comb begin
    mag_k   = delta_r[k_r][32] ? 33'(-delta_r[k_r]) : 33'(delta_r[k_r]);
    mag_yaw = delta_r[3][32] ? 33'(-delta_r[3]) : 33'(delta_r[3]);
    half_k  = mag_k[32:1];
    yw1 = 34'(delta_r[3]);
    if (yw1 > wli_pkg::PI_Q16) yw1 = yw1 - wli_pkg::TWO_PI_Q16;
    yw2 = yw1;
    if (yw2 < -wli_pkg::PI_Q16) yw2 = yw2 + wli_pkg::TWO_PI_Q16;
    tseg  = (tlin_r > div_q) ? tlin_r : div_q;
    mprod = 39'(i_r) * 39'(mag_k);
    // offset magnitude stays below 2^33
    off_s = delta_r[k_r][32] ? -35'(div_q[33:0]) : 35'(div_q[33:0]);
    sum_s = 35'(signed'(prev_r[k_r])) + off_s;
    if (sum_s > 35'sh0_7FFF_FFFF)       clamped = 32'h7FFF_FFFF;
    else if (sum_s < -35'sh0_8000_0000) clamped = 32'h8000_0000;
    else                                clamped = sum_s[31:0];
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = 32'd1;
    sq_start  = (state_r == S_SQACC);
    sq_in     = sum_r + prod_r;
    unique case (state_r)
      S_ROOT: begin
        div_start = sq_done;
        div_dvd   = {sq_root[30:0], 1'b0, 16'h0000} | 49'(sq_root[31]) << 48;
        div_dvs   = (speed_r == '0) ? 32'd1 : speed_r;
      end
      S_DLIN: begin
        div_start = div_done;
        div_dvd   = {mag_yaw, 16'h0000};
        div_dvs   = (yaw_r == '0) ? 32'd1 : yaw_r;
      end
      S_DYAW: begin
        div_start = div_done && (step_r != '0);
        div_dvd   = tseg;
        div_dvs   = step_r;
      end
      S_MUL: begin
        div_start = 1'b1;
        div_dvd   = wli_pkg::DVD_W'(mprod);
        div_dvs   = 32'(count_r);
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = {set_r[3], set_r[2], set_r[1], set_r[0]};
  assign out_tuser  = last_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr[3:2])
      wli_pkg::REG_SPEED: cfg_prdata = speed_r;
      wli_pkg::REG_YAW:   cfg_prdata = yaw_r;
      wli_pkg::REG_STEP:  cfg_prdata = step_r;
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= wli_pkg::SPEED_RST;
      yaw_r   <= wli_pkg::YAW_RST;
      step_r  <= wli_pkg::STEP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        wli_pkg::REG_SPEED: speed_r <= cfg_pwdata;
        wli_pkg::REG_YAW:   yaw_r   <= cfg_pwdata;
        wli_pkg::REG_STEP:  step_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      for (int n = 0; n < 4; n++) prev_r[n] <= '0;
      k_r     <= '0;
      i_r     <= '0;
      count_r <= '0;
      last_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_acc) begin
          for (int n = 0; n < 4; n++) begin
            cur_r[n]   <= in_tdata[32*n +: 32];
            delta_r[n] <= 33'(signed'(in_tdata[32*n +: 32])) - 33'(signed'(prev_r[n]));
          end
          if (in_tuser || !have_prev_r) begin
            for (int n = 0; n < 4; n++) prev_r[n] <= in_tdata[32*n +: 32];
            have_prev_r <= 1'b1;
          end else begin
            state_r <= S_WRAP;
          end
        end
        S_WRAP: begin
          delta_r[3] <= yw2[32:0];
          sum_r      <= '0;
          k_r        <= '0;
          state_r    <= S_SQ;
        end
        S_SQ: begin
          prod_r <= 64'(half_k) * 64'(half_k);
          if (k_r != 2'd0) sum_r <= sum_r + prod_r;
          k_r <= k_r + 1'b1;
          if (k_r == 2'd2) state_r <= S_SQACC;
        end
        S_SQACC: state_r <= S_ROOT;
        S_ROOT:  if (sq_done) state_r <= S_DLIN;
        S_DLIN: if (div_done) begin
          tlin_r  <= div_q;
          state_r <= S_DYAW;
        end
        S_DYAW: if (div_done) begin
          if (step_r == '0) begin
            count_r <= CW'(MAX_STEPS);
            i_r     <= '0;
            k_r     <= '0;
            state_r <= S_MUL;
          end else begin
            state_r <= S_DCNT;
          end
        end
        S_DCNT: if (div_done) begin
          i_r <= '0;
          k_r <= '0;
          if (div_q > wli_pkg::DVD_W'(MAX_STEPS)) begin
            count_r <= CW'(MAX_STEPS);
            state_r <= S_MUL;
          end else if (div_q == '0) begin
            for (int n = 0; n < 4; n++) prev_r[n] <= cur_r[n];
            state_r <= S_IDLE;
          end else begin
            count_r <= div_q[CW-1:0];
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_DOFF;
        S_DOFF: if (div_done) begin
          set_r[k_r] <= clamped;
          k_r        <= k_r + 1'b1;
          if (k_r == 2'd3) begin
            last_r  <= (CW'(i_r) + 1'b1 == count_r);
            state_r <= S_OUT;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_OUT: if (out_acc) begin
          if (last_r) begin
            for (int n = 0; n < 4; n++) prev_r[n] <= cur_r[n];
            state_r <= S_IDLE;
          end else begin
            i_r     <= i_r + 1'b1;
            k_r     <= '0;
            state_r <= S_MUL;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ---- checks ----
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input taken while a result beat is pending");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (CW'(i_r) < count_r && count_r <= CW'(MAX_STEPS)))
    else $error("setpoint index outside the segment");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser) |=> in_tready)
    else $error("sequencer did not return idle after the last beat");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DLIN || state_r == S_DYAW ||
                  state_r == S_DCNT || state_r == S_DOFF))
    else $error("divider finished outside a waiting state");

endmodule

FILE: hdl/wli_div.sv
// ----------------------------------------------------------------------------
// wli_div: iterative restoring divider
// One quotient bit per cycle; quotient valid when done pulses.
// ----------------------------------------------------------------------------
module wli_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [wli_pkg::DVD_W-1:0]    dividend,
  input  logic [wli_pkg::DVS_W-1:0]    divisor,
  output logic [wli_pkg::DVD_W-1:0]    quotient,
  output logic                         done
);

  localparam int unsigned CW = $clog2(wli_pkg::DVD_W + 1);

  logic [wli_pkg::DVD_W-1:0] q_r, q_nxt;
  logic [wli_pkg::DVS_W:0]   rem_r, rem_nxt;
  logic [wli_pkg::DVS_W-1:0] dvs_r;
  logic [CW-1:0]             cnt_r;
  logic                      busy_r, done_r;
  logic [wli_pkg::DVS_W:0]   trial;

  always_comb begin
    trial = {rem_r[wli_pkg::DVS_W-1:0], q_r[wli_pkg::DVD_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = trial - {1'b0, dvs_r};
      q_nxt   = {q_r[wli_pkg::DVD_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial;
      q_nxt   = {q_r[wli_pkg::DVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(wli_pkg::DVD_W);
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

FILE: hdl/wli_sqrt.sv
// ----------------------------------------------------------------------------
// wli_sqrt: iterative integer square root
// Digit-by-digit floor root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module wli_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic [31:0] root,
  output logic        done
);

  logic [63:0] op_r;
  logic [34:0] rem_r, rem_nxt, pre;
  logic [31:0] root_r, root_nxt;
  logic [33:0] trial;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;

  always_comb begin
    pre   = {rem_r[32:0], op_r[63:62]};
    trial = {root_r, 2'b01};
    if (pre >= {1'b0, trial}) begin
      rem_nxt  = pre - {1'b0, trial};
      root_nxt = {root_r[30:0], 1'b1};
    end else begin
      rem_nxt  = pre;
      root_nxt = {root_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
        op_r   <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        op_r   <= {op_r[61:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule
